// File: hw/rtl/amu_pkg.sv
package amu_pkg;

    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int DATA_W = 32;
    // accumulator: four full products plus a shifted translation, with sign
    localparam int ACC_W = 68;
    localparam int STEP_W = 5;

    // operation codes
    localparam logic [2:0] OP_IDENTITY  = 3'd0;
    localparam logic [2:0] OP_TRANSLATE = 3'd1;
    localparam logic [2:0] OP_SCALE     = 3'd2;
    localparam logic [2:0] OP_MULTIPLY  = 3'd3;
    localparam logic [2:0] OP_INVERT    = 3'd4;
    localparam logic [2:0] OP_POINT     = 3'd5;
    localparam logic [2:0] OP_INV_POINT = 3'd6;

    // micro-step kinds
    localparam logic [2:0] K_END   = 3'd0;
    localparam logic [2:0] K_MUL   = 3'd1;
    localparam logic [2:0] K_ADDT  = 3'd2;
    localparam logic [2:0] K_LOADV = 3'd3;
    localparam logic [2:0] K_WR    = 3'd4;
    localparam logic [2:0] K_DET   = 3'd5;
    localparam logic [2:0] K_DIV   = 3'd6;
    localparam logic [2:0] K_IDENT = 3'd7;

    // operand sources
    localparam logic [3:0] SRC_X    = 4'd0;
    localparam logic [3:0] SRC_Y    = 4'd1;
    localparam logic [3:0] SRC_SA   = 4'd2;
    localparam logic [3:0] SRC_SB   = 4'd3;
    localparam logic [3:0] SRC_SC   = 4'd4;
    localparam logic [3:0] SRC_SD   = 4'd5;
    localparam logic [3:0] SRC_STX  = 4'd6;
    localparam logic [3:0] SRC_STY  = 4'd7;
    localparam logic [3:0] SRC_MA   = 4'd8;
    localparam logic [3:0] SRC_MB   = 4'd9;
    localparam logic [3:0] SRC_MC   = 4'd10;
    localparam logic [3:0] SRC_MD   = 4'd11;
    localparam logic [3:0] SRC_MTX  = 4'd12;
    localparam logic [3:0] SRC_MTY  = 4'd13;
    localparam logic [3:0] SRC_NONE = 4'd14;

    // result destinations
    localparam logic [2:0] DST_A  = 3'd0;
    localparam logic [2:0] DST_B  = 3'd1;
    localparam logic [2:0] DST_C  = 3'd2;
    localparam logic [2:0] DST_D  = 3'd3;
    localparam logic [2:0] DST_TX = 3'd4;
    localparam logic [2:0] DST_TY = 3'd5;
    localparam logic [2:0] DST_OX = 3'd6;
    localparam logic [2:0] DST_OY = 3'd7;

    typedef struct packed {
        logic [2:0]        op;
        logic signed [31:0] x_in;
        logic signed [31:0] y_in;
        logic signed [31:0] src_a;
        logic signed [31:0] src_b;
        logic signed [31:0] src_c;
        logic signed [31:0] src_d;
        logic signed [31:0] src_tx;
        logic signed [31:0] src_ty;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic               singular;
        logic signed [31:0] cur_a;
        logic signed [31:0] cur_b;
        logic signed [31:0] cur_c;
        logic signed [31:0] cur_d;
        logic signed [31:0] cur_tx;
        logic signed [31:0] cur_ty;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] d;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
    } mat_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] src_p;
        logic [3:0] src_q;
        logic       neg;
        logic       first;
        logic       wide_shift;
        logic [2:0] dest;
    } uop_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic mul_phase;
        logic commit;
        uop_t uop;
    } ctrl_cmd_t;

    typedef struct packed {
        logic det_zero;
        logic div_done;
    } dp_status_t;

    function automatic uop_t u_mk(logic [2:0] kind, logic [3:0] p, logic [3:0] q,
                                  logic neg, logic first, logic wide, logic [2:0] dest);
        uop_t u;
        u.kind       = kind;
        u.src_p      = p;
        u.src_q      = q;
        u.neg        = neg;
        u.first      = first;
        u.wide_shift = wide;
        u.dest       = dest;
        return u;
    endfunction

    function automatic uop_t u_mul(logic [3:0] p, logic [3:0] q, logic neg, logic first);
        return u_mk(K_MUL, p, q, neg, first, 1'b0, DST_A);
    endfunction

    function automatic uop_t u_wr(logic [2:0] dest);
        return u_mk(K_WR, SRC_NONE, SRC_NONE, 1'b0, 1'b0, 1'b0, dest);
    endfunction

    function automatic uop_t u_addt(logic [3:0] p);
        return u_mk(K_ADDT, p, SRC_NONE, 1'b0, 1'b0, 1'b0, DST_A);
    endfunction

    function automatic uop_t u_loadv(logic [3:0] p, logic neg);
        return u_mk(K_LOADV, p, SRC_NONE, neg, 1'b0, 1'b0, DST_A);
    endfunction

    function automatic uop_t u_div(logic wide, logic [2:0] dest);
        return u_mk(K_DIV, SRC_NONE, SRC_NONE, 1'b0, 1'b0, wide, dest);
    endfunction

    function automatic uop_t u_kind(logic [2:0] kind);
        return u_mk(kind, SRC_NONE, SRC_NONE, 1'b0, 1'b0, 1'b0, DST_A);
    endfunction

    // Micro-program: one step list per operation, ends on K_END.
    function automatic uop_t prog(logic [2:0] op, logic [STEP_W-1:0] step);
        uop_t u;
        u = u_kind(K_END);
        case (op)
            OP_IDENTITY:
                case (step)
                    5'd0:    u = u_kind(K_IDENT);
                    default: u = u_kind(K_END);
                endcase
            OP_TRANSLATE:
                case (step)
                    5'd0:    u = u_mul(SRC_MA, SRC_X, 1'b0, 1'b1);
                    5'd1:    u = u_mul(SRC_MC, SRC_Y, 1'b0, 1'b0);
                    5'd2:    u = u_addt(SRC_MTX);
                    5'd3:    u = u_wr(DST_TX);
                    5'd4:    u = u_mul(SRC_MB, SRC_X, 1'b0, 1'b1);
                    5'd5:    u = u_mul(SRC_MD, SRC_Y, 1'b0, 1'b0);
                    5'd6:    u = u_addt(SRC_MTY);
                    5'd7:    u = u_wr(DST_TY);
                    default: u = u_kind(K_END);
                endcase
            OP_SCALE:
                case (step)
                    5'd0:    u = u_mul(SRC_MA, SRC_X, 1'b0, 1'b1);
                    5'd1:    u = u_wr(DST_A);
                    5'd2:    u = u_mul(SRC_MB, SRC_X, 1'b0, 1'b1);
                    5'd3:    u = u_wr(DST_B);
                    5'd4:    u = u_mul(SRC_MC, SRC_Y, 1'b0, 1'b1);
                    5'd5:    u = u_wr(DST_C);
                    5'd6:    u = u_mul(SRC_MD, SRC_Y, 1'b0, 1'b1);
                    5'd7:    u = u_wr(DST_D);
                    default: u = u_kind(K_END);
                endcase
            OP_MULTIPLY:
                case (step)
                    5'd0:    u = u_mul(SRC_SA, SRC_MA, 1'b0, 1'b1);
                    5'd1:    u = u_mul(SRC_SB, SRC_MC, 1'b0, 1'b0);
                    5'd2:    u = u_wr(DST_A);
                    5'd3:    u = u_mul(SRC_SA, SRC_MB, 1'b0, 1'b1);
                    5'd4:    u = u_mul(SRC_SB, SRC_MD, 1'b0, 1'b0);
                    5'd5:    u = u_wr(DST_B);
                    5'd6:    u = u_mul(SRC_SC, SRC_MA, 1'b0, 1'b1);
                    5'd7:    u = u_mul(SRC_SD, SRC_MC, 1'b0, 1'b0);
                    5'd8:    u = u_wr(DST_C);
                    5'd9:    u = u_mul(SRC_SC, SRC_MB, 1'b0, 1'b1);
                    5'd10:   u = u_mul(SRC_SD, SRC_MD, 1'b0, 1'b0);
                    5'd11:   u = u_wr(DST_D);
                    5'd12:   u = u_mul(SRC_STX, SRC_MA, 1'b0, 1'b1);
                    5'd13:   u = u_mul(SRC_STY, SRC_MC, 1'b0, 1'b0);
                    5'd14:   u = u_mul(SRC_X, SRC_MA, 1'b0, 1'b0);
                    5'd15:   u = u_mul(SRC_Y, SRC_MC, 1'b0, 1'b0);
                    5'd16:   u = u_addt(SRC_MTX);
                    5'd17:   u = u_wr(DST_TX);
                    5'd18:   u = u_mul(SRC_STX, SRC_MB, 1'b0, 1'b1);
                    5'd19:   u = u_mul(SRC_STY, SRC_MD, 1'b0, 1'b0);
                    5'd20:   u = u_mul(SRC_X, SRC_MB, 1'b0, 1'b0);
                    5'd21:   u = u_mul(SRC_Y, SRC_MD, 1'b0, 1'b0);
                    5'd22:   u = u_addt(SRC_MTY);
                    5'd23:   u = u_wr(DST_TY);
                    default: u = u_kind(K_END);
                endcase
            OP_INVERT:
                case (step)
                    5'd0:    u = u_mul(SRC_MA, SRC_MD, 1'b0, 1'b1);
                    5'd1:    u = u_mul(SRC_MB, SRC_MC, 1'b1, 1'b0);
                    5'd2:    u = u_kind(K_DET);
                    5'd3:    u = u_loadv(SRC_MD, 1'b0);
                    5'd4:    u = u_div(1'b1, DST_A);
                    5'd5:    u = u_loadv(SRC_MB, 1'b1);
                    5'd6:    u = u_div(1'b1, DST_B);
                    5'd7:    u = u_loadv(SRC_MC, 1'b1);
                    5'd8:    u = u_div(1'b1, DST_C);
                    5'd9:    u = u_loadv(SRC_MA, 1'b0);
                    5'd10:   u = u_div(1'b1, DST_D);
                    5'd11:   u = u_mul(SRC_MC, SRC_MTY, 1'b0, 1'b1);
                    5'd12:   u = u_mul(SRC_MD, SRC_MTX, 1'b1, 1'b0);
                    5'd13:   u = u_div(1'b0, DST_TX);
                    5'd14:   u = u_mul(SRC_MB, SRC_MTX, 1'b0, 1'b1);
                    5'd15:   u = u_mul(SRC_MA, SRC_MTY, 1'b1, 1'b0);
                    5'd16:   u = u_div(1'b0, DST_TY);
                    default: u = u_kind(K_END);
                endcase
            OP_POINT:
                case (step)
                    5'd0:    u = u_mul(SRC_X, SRC_MA, 1'b0, 1'b1);
                    5'd1:    u = u_mul(SRC_Y, SRC_MC, 1'b0, 1'b0);
                    5'd2:    u = u_addt(SRC_MTX);
                    5'd3:    u = u_wr(DST_OX);
                    5'd4:    u = u_mul(SRC_X, SRC_MB, 1'b0, 1'b1);
                    5'd5:    u = u_mul(SRC_Y, SRC_MD, 1'b0, 1'b0);
                    5'd6:    u = u_addt(SRC_MTY);
                    5'd7:    u = u_wr(DST_OY);
                    default: u = u_kind(K_END);
                endcase
            OP_INV_POINT:
                case (step)
                    5'd0:    u = u_mul(SRC_MA, SRC_MD, 1'b0, 1'b1);
                    5'd1:    u = u_mul(SRC_MB, SRC_MC, 1'b1, 1'b0);
                    5'd2:    u = u_kind(K_DET);
                    5'd3:    u = u_mul(SRC_MD, SRC_X, 1'b0, 1'b1);
                    5'd4:    u = u_mul(SRC_MC, SRC_Y, 1'b1, 1'b0);
                    5'd5:    u = u_mul(SRC_MC, SRC_MTY, 1'b0, 1'b0);
                    5'd6:    u = u_mul(SRC_MD, SRC_MTX, 1'b1, 1'b0);
                    5'd7:    u = u_div(1'b0, DST_OX);
                    5'd8:    u = u_mul(SRC_MA, SRC_Y, 1'b0, 1'b1);
                    5'd9:    u = u_mul(SRC_MB, SRC_X, 1'b1, 1'b0);
                    5'd10:   u = u_mul(SRC_MB, SRC_MTX, 1'b0, 1'b0);
                    5'd11:   u = u_mul(SRC_MA, SRC_MTY, 1'b1, 1'b0);
                    5'd12:   u = u_div(1'b0, DST_OY);
                    default: u = u_kind(K_END);
                endcase
            default: u = u_kind(K_END);
        endcase
        return u;
    endfunction

endpackage

// File: hw/rtl/amu_in_if.sv
interface amu_in_if;
    logic               valid;
    logic               ready;
    amu_pkg::in_item_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/amu_out_if.sv
interface amu_out_if;
    logic               valid;
    logic               ready;
    amu_pkg::out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/affine_matrix_unit_2d.sv
// 2D affine matrix unit. Holds one matrix (a, b, c, d, tx, ty) in signed fixed
// point with FRAC_BITS fraction bits and applies one operation per input
// transfer: load identity, translate, scale, multiply by a source matrix with
// an (x, y) offset, invert, transform a point or inverse-transform a point.
// Each input transfer yields exactly one output transfer carrying the point
// (zero for matrix operations), the singular flag and the matrix as it stands
// after the operation. One item is worked on at a time; the result sits in an
// output register, so the next input transfer is taken while it waits. Timing
// is set by the single shared 32x32 multiplier and the single restoring
// divider. Invert or inverse point on a zero determinant stops at the
// determinant check. The default FRAC_BITS of 16 gives Q16.16 values. The
// next input transfer can be taken in the cycle the result first appears.
module affine_matrix_unit_2d #(
    parameter int FRAC_BITS = amu_pkg::FRAC_BITS_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    amu_in_if.sink    in_ch,
    amu_out_if.source out_ch
);
    import amu_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencer: steps the micro-program for the latched operation
    amu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_op     (in_ch.payload.op),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath: operand latch, matrix store, multiply-accumulate, divider
    amu_datapath #(
        .FRAC_BITS(FRAC_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_item  (in_ch.payload),
        .out_item (out_ch.payload),
        .status   (status)
    );

endmodule

// File: hw/rtl/amu_divider.sv
module amu_divider #(
    parameter int NUM_W = 82
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [62:0]      den,
    input  logic             neg,
    input  logic             zero_res,
    output logic             done,
    output logic [31:0]      quo
);
    import amu_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [62:0]      den_reg, den_next;
    logic [62:0]      rem_reg, rem_next;
    logic [31:0]      q_reg, q_next;
    logic             ovf_reg, ovf_next;
    logic             neg_reg, neg_next;
    logic             zero_reg, zero_next;

    logic [63:0] trial;
    logic [63:0] diff;
    logic        ge;
    logic        rnd;
    logic [32:0] q_rnd;
    logic        sat;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            q_next    = '0;
            ovf_next  = 1'b0;
            neg_next  = neg;
            zero_next = zero_res;
        end
        else if (busy_reg)
        begin
            // one restoring step per cycle, overflow flag held sticky once the quotient overflows
            num_next = num_reg << 1;
            rem_next = ge ? diff[62:0] : trial[62:0];
            q_next   = {q_reg[30:0], ge};
            ovf_next = ovf_reg | q_reg[31];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        ovf_reg  <= ovf_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
    end

    // round to nearest, ties away from zero, then saturate
    assign rnd   = {rem_reg, 1'b0} >= {1'b0, den_reg};
    assign q_rnd = {1'b0, q_reg} + {32'd0, rnd};
    assign sat   = ovf_reg | q_rnd[32] | q_rnd[31];

    always_comb
    begin
        if (zero_reg)
            quo = '0;
        else if (neg_reg)
            quo = sat ? 32'h8000_0000 : (32'd0 - q_rnd[31:0]);
        else
            quo = sat ? 32'h7FFF_FFFF : q_rnd[31:0];
    end

    assign done = done_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");

endmodule

// File: hw/rtl/amu_datapath.sv
module amu_datapath #(
    parameter int FRAC_BITS = amu_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  amu_pkg::ctrl_cmd_t  cmd,
    input  amu_pkg::in_item_t   in_item,
    output amu_pkg::out_item_t  out_item,
    output amu_pkg::dp_status_t status
);
    import amu_pkg::*;

    localparam int NUM_W = 66 + FRAC_BITS;
    localparam logic signed [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

    in_item_t  in_reg;
    mat_t      mat_reg, mat_next;
    mat_t      new_reg, new_next;
    logic signed [31:0] ox_reg, ox_next;
    logic signed [31:0] oy_reg, oy_next;
    logic      sing_reg, sing_next;
    out_item_t out_reg;
    logic signed [63:0]      prod_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] det_reg;
    logic [2:0]              dest_reg;

    mat_t identity;
    logic signed [31:0] p_val, q_val;
    logic signed [63:0] prod_full;
    logic signed [ACC_W-1:0] prod_ext, base, p_ext;
    logic signed [ACC_W-1:0] rnd_sum, rnd_sh;
    logic [31:0] rnd_val;
    logic [ACC_W-1:0] acc_mag, det_mag;
    logic [NUM_W-1:0] num_mag;
    logic        div_start, div_done;
    logic [31:0] div_quo;
    logic        wr_en;
    logic [2:0]  wr_dest;
    logic [31:0] wr_val;
    logic        step_mul, step_wr;

    function automatic logic signed [31:0] pick(logic [3:0] code, in_item_t i, mat_t m);
        case (code)
            SRC_X:   return i.x_in;
            SRC_Y:   return i.y_in;
            SRC_SA:  return i.src_a;
            SRC_SB:  return i.src_b;
            SRC_SC:  return i.src_c;
            SRC_SD:  return i.src_d;
            SRC_STX: return i.src_tx;
            SRC_STY: return i.src_ty;
            SRC_MA:  return m.a;
            SRC_MB:  return m.b;
            SRC_MC:  return m.c;
            SRC_MD:  return m.d;
            SRC_MTX: return m.tx;
            SRC_MTY: return m.ty;
            default: return '0;
        endcase
    endfunction

    always_comb
    begin
        identity    = '0;
        identity.a  = ONE;
        identity.d  = ONE;
    end

    assign p_val     = pick(cmd.uop.src_p, in_reg, mat_reg);
    assign q_val     = pick(cmd.uop.src_q, in_reg, mat_reg);
    assign prod_full = p_val * q_val;
    assign prod_ext  = ACC_W'(prod_reg);
    assign p_ext     = ACC_W'(p_val);
    assign base      = cmd.uop.first ? '0 : acc_reg;
    assign step_mul  = cmd.exec && (cmd.uop.kind == K_MUL);
    assign step_wr   = cmd.exec && (cmd.uop.kind == K_WR);

    always_comb
    begin
        acc_next = acc_reg;
        if (step_mul && cmd.mul_phase)
            acc_next = cmd.uop.neg ? (base - prod_ext) : (base + prod_ext);
        else if (cmd.exec && (cmd.uop.kind == K_ADDT))
            acc_next = acc_reg + (p_ext <<< FRAC_BITS);
        else if (cmd.exec && (cmd.uop.kind == K_LOADV))
            acc_next = cmd.uop.neg ? -p_ext : p_ext;
    end

    // round half up, then saturate to 32 bits
    assign rnd_sum = acc_reg + (ACC_W'(1) <<< (FRAC_BITS - 1));
    assign rnd_sh  = rnd_sum >>> FRAC_BITS;

    always_comb
    begin
        if (!rnd_sh[ACC_W-1] && (|rnd_sh[ACC_W-2:31]))
            rnd_val = 32'h7FFF_FFFF;
        else if (rnd_sh[ACC_W-1] && !(&rnd_sh[ACC_W-2:31]))
            rnd_val = 32'h8000_0000;
        else
            rnd_val = rnd_sh[31:0];
    end

    // divider operands: magnitudes and sign of the quotient
    assign acc_mag   = acc_reg[ACC_W-1] ? (ACC_W'(0) - acc_reg) : acc_reg;
    assign det_mag   = det_reg[ACC_W-1] ? (ACC_W'(0) - det_reg) : det_reg;
    assign num_mag   = cmd.uop.wide_shift ? (NUM_W'(acc_mag) << (2 * FRAC_BITS))
                                          : (NUM_W'(acc_mag) << FRAC_BITS);
    assign div_start = cmd.exec && (cmd.uop.kind == K_DIV);

    amu_divider #(
        .NUM_W(NUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (num_mag),
        .den      (det_mag[62:0]),
        .neg      (acc_reg[ACC_W-1] ^ det_reg[ACC_W-1]),
        .zero_res (|det_mag[ACC_W-1:63]),
        .done     (div_done),
        .quo      (div_quo)
    );

    assign wr_en   = step_wr || div_done;
    assign wr_dest = div_done ? dest_reg : cmd.uop.dest;
    assign wr_val  = div_done ? div_quo : rnd_val;

    always_comb
    begin
        new_next  = new_reg;
        ox_next   = ox_reg;
        oy_next   = oy_reg;
        sing_next = sing_reg;
        if (cmd.load)
        begin
            new_next  = mat_reg;
            ox_next   = '0;
            oy_next   = '0;
            sing_next = 1'b0;
        end
        else
        begin
            if (cmd.exec && (cmd.uop.kind == K_IDENT))
                new_next = identity;
            if (cmd.exec && (cmd.uop.kind == K_DET) && (acc_reg == '0))
                sing_next = 1'b1;
            if (wr_en)
            begin
                case (wr_dest)
                    DST_A:   new_next.a  = wr_val;
                    DST_B:   new_next.b  = wr_val;
                    DST_C:   new_next.c  = wr_val;
                    DST_D:   new_next.d  = wr_val;
                    DST_TX:  new_next.tx = wr_val;
                    DST_TY:  new_next.ty = wr_val;
                    DST_OX:  ox_next     = wr_val;
                    DST_OY:  oy_next     = wr_val;
                    default: ox_next     = ox_reg;
                endcase
            end
        end
    end

    assign mat_next = cmd.commit ? new_reg : mat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mat_reg <= identity;
        else
            mat_reg <= mat_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            in_reg <= in_item;
        if (step_mul && !cmd.mul_phase)
            prod_reg <= prod_full;
        if (cmd.exec && (cmd.uop.kind == K_DET))
            det_reg <= acc_reg;
        if (div_start)
            dest_reg <= cmd.uop.dest;
        if (cmd.commit)
            out_reg <= '{ox_reg, oy_reg, sing_reg, new_reg.a, new_reg.b, new_reg.c,
                         new_reg.d, new_reg.tx, new_reg.ty};
        acc_reg  <= acc_next;
        new_reg  <= new_next;
        ox_reg   <= ox_next;
        oy_reg   <= oy_next;
        sing_reg <= sing_next;
    end

    assign out_item        = out_reg;
    assign status.det_zero = (acc_reg == '0);
    assign status.div_done = div_done;

endmodule

// File: hw/rtl/amu_ctrl.sv
module amu_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          in_op,
    output logic                out_valid,
    input  logic                out_ready,
    input  amu_pkg::dp_status_t status,
    output amu_pkg::ctrl_cmd_t  cmd
);
    import amu_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DIVW = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [2:0]        op_reg, op_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              phase_reg, phase_next;
    logic              out_valid_reg, out_valid_next;

    uop_t uop;
    logic in_fire;
    logic out_free;

    assign uop      = prog(op_reg, step_reg);
    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd.load      = in_fire;
        cmd.exec      = (state_reg == S_RUN);
        cmd.mul_phase = phase_reg;
        cmd.commit    = (state_reg == S_FIN) && out_free;
        cmd.uop       = uop;
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        step_next  = step_reg;
        phase_next = phase_reg;
        case (state_reg)
            S_IDLE:
                if (in_fire)
                begin
                    op_next    = in_op;
                    step_next  = '0;
                    phase_next = 1'b0;
                    state_next = S_RUN;
                end
            S_RUN:
                case (uop.kind)
                    K_MUL:
                        if (phase_reg)
                        begin
                            phase_next = 1'b0;
                            step_next  = step_reg + 1'b1;
                        end
                        else
                            phase_next = 1'b1;
                    K_DET:
                        if (status.det_zero)
                            state_next = S_FIN;
                        else
                            step_next = step_reg + 1'b1;
                    K_DIV:
                        state_next = S_DIVW;
                    K_END:
                        state_next = S_FIN;
                    default:
                        step_next = step_reg + 1'b1;
                endcase
            S_DIVW:
                if (status.div_done)
                begin
                    step_next  = step_reg + 1'b1;
                    state_next = S_RUN;
                end
            S_FIN:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_IDENTITY;
            step_reg      <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            step_reg      <= step_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_RUN) && (step_reg == '0))
        else $error("accepted item did not start the sequence");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_FIN) && out_free) |=> out_valid_reg && (state_reg == S_IDLE))
        else $error("finished item not presented");

endmodule

// File: sim/affine_matrix_checker.sv
`timescale 1ns / 100ps

module affine_matrix_checker (
    input  logic      clk,
    input  logic      rst_n,
    amu_in_if         in_ch,
    amu_out_if        out_ch,
    output int        mismatches,
    output int        outstanding
);
    import amu_pkg::*;

    localparam int FRAC = FRAC_BITS_DEFAULT;

    typedef logic signed [129:0] acc_t;

    mat_t      model_mat;
    out_item_t expected_q[$];

    function automatic acc_t ext(logic signed [31:0] v);
        return acc_t'(v);
    endfunction

    function automatic acc_t mul(logic signed [31:0] p, logic signed [31:0] q);
        return ext(p) * ext(q);
    endfunction

    function automatic logic signed [31:0] clamp(acc_t v);
        if (v > acc_t'(32'sh7FFF_FFFF))
            return 32'sh7FFF_FFFF;
        if (v < -(acc_t'(1) <<< 31))
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // round half up from Q(2F) to QF, then clamp
    function automatic logic signed [31:0] round_q(acc_t s);
        return clamp((s + (acc_t'(1) <<< (FRAC - 1))) >>> FRAC);
    endfunction

    // quotient rounded to nearest, ties away from zero, then clamp
    function automatic logic signed [31:0] quot(acc_t num, acc_t den);
        logic              neg;
        logic [129:0]      nm;
        logic [129:0]      dm;
        logic [129:0]      q;
        logic [129:0]      r;
        neg = (num < 0) != (den < 0);
        nm  = (num < 0) ? -num : num;
        dm  = (den < 0) ? -den : den;
        if (dm == 0 || dm >= (130'd1 << 63))
            return 32'sd0;
        q = nm / dm;
        r = nm - q * dm;
        if (2 * r >= dm)
            q = q + 1;
        if (neg)
            return (q >= 130'h8000_0000) ? 32'sh8000_0000 : -q[31:0];
        return (q > 130'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q[31:0];
    endfunction

    // apply one operation to the model matrix and return the expected result
    function automatic out_item_t apply_op(in_item_t it);
        out_item_t r;
        mat_t      m;
        acc_t      txw;
        acc_t      tyw;
        acc_t      det;
        acc_t      n1;
        acc_t      n2;
        m   = model_mat;
        r   = '0;
        txw = ext(m.tx) <<< FRAC;
        tyw = ext(m.ty) <<< FRAC;
        det = mul(m.a, m.d) - mul(m.b, m.c);
        case (it.op)
            OP_IDENTITY:
            begin
                model_mat = '{a: 32'sh1 <<< FRAC, b: 0, c: 0, d: 32'sh1 <<< FRAC, tx: 0, ty: 0};
            end
            OP_TRANSLATE:
            begin
                model_mat.tx = round_q(mul(m.a, it.x_in) + mul(m.c, it.y_in) + txw);
                model_mat.ty = round_q(mul(m.b, it.x_in) + mul(m.d, it.y_in) + tyw);
            end
            OP_SCALE:
            begin
                model_mat.a = round_q(mul(m.a, it.x_in));
                model_mat.b = round_q(mul(m.b, it.x_in));
                model_mat.c = round_q(mul(m.c, it.y_in));
                model_mat.d = round_q(mul(m.d, it.y_in));
            end
            OP_MULTIPLY:
            begin
                model_mat.a  = round_q(mul(it.src_a, m.a) + mul(it.src_b, m.c));
                model_mat.b  = round_q(mul(it.src_a, m.b) + mul(it.src_b, m.d));
                model_mat.c  = round_q(mul(it.src_c, m.a) + mul(it.src_d, m.c));
                model_mat.d  = round_q(mul(it.src_c, m.b) + mul(it.src_d, m.d));
                model_mat.tx = round_q(mul(it.src_tx, m.a) + mul(it.src_ty, m.c)
                                       + mul(it.x_in, m.a) + mul(it.y_in, m.c) + txw);
                model_mat.ty = round_q(mul(it.src_tx, m.b) + mul(it.src_ty, m.d)
                                       + mul(it.x_in, m.b) + mul(it.y_in, m.d) + tyw);
            end
            OP_INVERT:
            begin
                if (det == 0)
                    r.singular = 1'b1;
                else
                begin
                    model_mat.a  = quot(ext(m.d) <<< (2 * FRAC), det);
                    model_mat.b  = quot(-(ext(m.b) <<< (2 * FRAC)), det);
                    model_mat.c  = quot(-(ext(m.c) <<< (2 * FRAC)), det);
                    model_mat.d  = quot(ext(m.a) <<< (2 * FRAC), det);
                    n1 = mul(m.c, m.ty) - mul(m.d, m.tx);
                    n2 = mul(m.b, m.tx) - mul(m.a, m.ty);
                    model_mat.tx = quot(n1 <<< FRAC, det);
                    model_mat.ty = quot(n2 <<< FRAC, det);
                end
            end
            OP_POINT:
            begin
                r.out_x = round_q(mul(it.x_in, m.a) + mul(it.y_in, m.c) + txw);
                r.out_y = round_q(mul(it.x_in, m.b) + mul(it.y_in, m.d) + tyw);
            end
            OP_INV_POINT:
            begin
                if (det == 0)
                    r.singular = 1'b1;
                else
                begin
                    n1 = mul(m.d, it.x_in) - mul(m.c, it.y_in) + mul(m.c, m.ty) - mul(m.d, m.tx);
                    n2 = mul(m.a, it.y_in) - mul(m.b, it.x_in) + mul(m.b, m.tx) - mul(m.a, m.ty);
                    r.out_x = quot(n1 <<< FRAC, det);
                    r.out_y = quot(n2 <<< FRAC, det);
                end
            end
            default:
            begin
            end
        endcase
        r.cur_a  = model_mat.a;
        r.cur_b  = model_mat.b;
        r.cur_c  = model_mat.c;
        r.cur_d  = model_mat.d;
        r.cur_tx = model_mat.tx;
        r.cur_ty = model_mat.ty;
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic compare(out_item_t got, out_item_t want);
        if (got.out_x !== want.out_x)       report("out_x", got.out_x, want.out_x);
        if (got.out_y !== want.out_y)       report("out_y", got.out_y, want.out_y);
        if (got.singular !== want.singular) report("singular", got.singular, want.singular);
        if (got.cur_a !== want.cur_a)       report("cur_a", got.cur_a, want.cur_a);
        if (got.cur_b !== want.cur_b)       report("cur_b", got.cur_b, want.cur_b);
        if (got.cur_c !== want.cur_c)       report("cur_c", got.cur_c, want.cur_c);
        if (got.cur_d !== want.cur_d)       report("cur_d", got.cur_d, want.cur_d);
        if (got.cur_tx !== want.cur_tx)     report("cur_tx", got.cur_tx, want.cur_tx);
        if (got.cur_ty !== want.cur_ty)     report("cur_ty", got.cur_ty, want.cur_ty);
    endtask

    initial
    begin
        mismatches = 0;
    end

    assign outstanding = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_mat = '{a: 32'sh1 <<< FRAC, b: 0, c: 0, d: 32'sh1 <<< FRAC, tx: 0, ty: 0};
            expected_q.delete();
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                expected_q.push_back(apply_op(in_ch.payload));
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_q.size() == 0)
                    report("unexpected transfer", 32'd1, 32'd0);
                else
                    compare(out_ch.payload, expected_q.pop_front());
            end
        end
    end

endmodule

// File: sim/tb_affine_matrix_unit_2d.sv
`timescale 1ns / 100ps

module tb_affine_matrix_unit_2d;
    import amu_pkg::*;

    // op code 7 is not decoded by the block; it must leave the matrix alone
    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam int RANDOM_OPS = 1300;
    localparam int CALM_TAIL = 150;
    localparam int CYCLE_LIMIT = 2_500_000;
    localparam logic signed [31:0] ONE = 32'sh0001_0000;
    localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MINV = 32'sh8000_0000;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    int   sent;
    int   op_hist[8];
    logic calm;
    logic hold_off;
    int   cycles;

    amu_in_if  in_ch();
    amu_out_if out_ch();

    affine_matrix_unit_2d u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    affine_matrix_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Build one operation; the source matrix only matters for multiply.
    function automatic in_item_t make_op(logic [2:0] op, logic signed [31:0] x,
                                         logic signed [31:0] y,
                                         logic signed [31:0] sa = 0, logic signed [31:0] sb = 0,
                                         logic signed [31:0] sc = 0, logic signed [31:0] sd = 0,
                                         logic signed [31:0] stx = 0, logic signed [31:0] sty = 0);
        in_item_t it;
        it.op     = op;
        it.x_in   = x;
        it.y_in   = y;
        it.src_a  = sa;
        it.src_b  = sb;
        it.src_c  = sc;
        it.src_d  = sd;
        it.src_tx = stx;
        it.src_ty = sty;
        return it;
    endfunction

    // Operand mix: mostly modest Q16.16 values so the matrix stays in range,
    // with whole numbers, zero, the extremes and raw 32-bit noise mixed in.
    function automatic logic signed [31:0] pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 45)
            return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        if (sel < 60)
            return ($signed($urandom_range(0, 8)) - 4) <<< 16;
        if (sel < 65)
            return 32'sd0;
        if (sel < 70)
            return ($urandom_range(0, 1) != 0) ? MAXV : MINV;
        return $signed($urandom());
    endfunction

    function automatic logic [2:0] pick_op();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 8)  return OP_IDENTITY;
        if (sel < 23) return OP_TRANSLATE;
        if (sel < 35) return OP_SCALE;
        if (sel < 50) return OP_MULTIPLY;
        if (sel < 60) return OP_INVERT;
        if (sel < 80) return OP_POINT;
        if (sel < 95) return OP_INV_POINT;
        return OP_UNUSED;
    endfunction

    // Offer one operation and hold it until the block takes it.
    task automatic offer(in_item_t it);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_ch.payload = it;
        in_ch.valid   = 1'b1;
        do
            @(posedge clk);
        while (!in_ch.ready);
        op_hist[it.op]++;
        sent++;
        @(negedge clk);
    endtask

    // Result side: short random stalls, plus the long hold-off when asked.
    initial
    begin
        int gap;
        gap = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (gap > 0)
                gap--;
            else if (!calm && $urandom_range(0, 4) == 0)
                gap = $urandom_range(1, 3);
            out_ch.ready = !hold_off && gap == 0;
        end
    end

    // Hold the result side off long enough for the block to back up its input.
    initial
    begin
        hold_off = 1'b0;
        wait (sent >= 300);
        @(negedge clk);
        hold_off = 1'b1;
        repeat (2000) @(negedge clk);
        hold_off = 1'b0;
    end

    // Watchdog.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("tb_affine_matrix_unit_2d failed");
                $finish;
            end
        end
    end

    initial
    begin
        in_item_t directed[$];
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        calm          = 1'b0;
        sent          = 0;
        foreach (op_hist[i])
            op_hist[i] = 0;
        rst_n = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: every op, field extremes, singular matrices, unused code
        directed.push_back(make_op(OP_POINT, ONE, -ONE));
        directed.push_back(make_op(OP_INV_POINT, MAXV, MINV));
        directed.push_back(make_op(OP_TRANSLATE, 32'sh0002_8000, -32'sh0001_4000));
        directed.push_back(make_op(OP_SCALE, 32'sh0002_0000, 32'sh0000_8000));
        directed.push_back(make_op(OP_INVERT, 0, 0));
        directed.push_back(make_op(OP_POINT, MAXV, MAXV));
        directed.push_back(make_op(OP_MULTIPLY, 0, 0, ONE, ONE, -ONE, ONE, ONE, ONE));
        directed.push_back(make_op(OP_MULTIPLY, MAXV, MINV, MAXV, MINV, MINV, MAXV,
                                   MINV, MAXV));
        directed.push_back(make_op(OP_POINT, MINV, MINV));
        directed.push_back(make_op(OP_INVERT, 0, 0));
        directed.push_back(make_op(OP_IDENTITY, MAXV, MINV));
        directed.push_back(make_op(OP_SCALE, MAXV, MINV));
        directed.push_back(make_op(OP_TRANSLATE, MAXV, MINV));
        directed.push_back(make_op(OP_INVERT, 0, 0));
        directed.push_back(make_op(OP_SCALE, 0, ONE));
        directed.push_back(make_op(OP_INVERT, 0, 0));
        directed.push_back(make_op(OP_INV_POINT, ONE, ONE));
        directed.push_back(make_op(OP_UNUSED, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV,
                                   MAXV, MAXV));
        directed.push_back(make_op(OP_IDENTITY, 0, 0));
        directed.push_back(make_op(OP_TRANSLATE, ONE, 32'sh0000_0001));
        directed.push_back(make_op(OP_SCALE, -32'sh0000_0003, 32'sh0000_0001));
        directed.push_back(make_op(OP_INVERT, 0, 0));
        directed.push_back(make_op(OP_INV_POINT, -ONE, 32'sh0000_7FFF));
        directed.push_back(make_op(OP_IDENTITY, 0, 0));
        foreach (directed[i])
            offer(directed[i]);

        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            if (n == RANDOM_OPS - CALM_TAIL)
                calm = 1'b1;
            offer(make_op(pick_op(), pick_value(), pick_value(), pick_value(), pick_value(),
                          pick_value(), pick_value(), pick_value(), pick_value()));
        end
        in_ch.valid = 1'b0;

        // drain, then allow for the slowest operation to settle
        wait (outstanding == 0);
        repeat (600) @(posedge clk);

        $display("covered %0d transfers: identity %0d, translate %0d, scale %0d, multiply %0d",
                 sent, op_hist[OP_IDENTITY], op_hist[OP_TRANSLATE], op_hist[OP_SCALE],
                 op_hist[OP_MULTIPLY]);
        $display("invert %0d, point %0d, inverse point %0d, unused code %0d; mismatches %0d",
                 op_hist[OP_INVERT], op_hist[OP_POINT], op_hist[OP_INV_POINT],
                 op_hist[OP_UNUSED], mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("tb_affine_matrix_unit_2d passed");
        else
            $display("tb_affine_matrix_unit_2d failed");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/amu_pkg.sv
hw/rtl/amu_in_if.sv
hw/rtl/amu_out_if.sv
hw/rtl/amu_divider.sv
hw/rtl/amu_datapath.sv
hw/rtl/amu_ctrl.sv
hw/rtl/affine_matrix_unit_2d.sv
sim/affine_matrix_checker.sv
sim/tb_affine_matrix_unit_2d.sv
